FILE: src/mfwf_pkg.sv
// Shared constants and types for the most frequent window finder.
`default_nettype none
package mfwf_pkg;
  localparam int unsigned MAX_LEN    = 1024;
  localparam int unsigned ADDR_W     = $clog2(MAX_LEN);
  localparam int unsigned CNT_W      = ADDR_W + 1;
  localparam int unsigned MAX_WINDOW = 64;
  localparam int unsigned WIN_W      = $clog2(MAX_WINDOW) + 1;
  localparam int unsigned POS_W      = 6;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [5:0]  byte_position;
    logic [9:0]  window_start;
    logic [10:0] occurrence_count;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic shift_s;
    logic shift_p;
  } chain_ctrl_t;
endpackage
`default_nettype wire

FILE: src/mfwf_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module mfwf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: src/mfwf_cell.sv
// One compare cell: a stream byte and a pattern byte, both shifted along the row.
`default_nettype none
module mfwf_cell import mfwf_pkg::*; (
  input  wire logic        clk_i,
  input  wire chain_ctrl_t ctrl_i,
  input  wire logic        active_i,
  input  wire logic [7:0]  s_i,
  input  wire logic [7:0]  p_i,
  output logic      [7:0]  s_o,
  output logic      [7:0]  p_o,
  output logic             eq_o
);
  logic [7:0] s_q, p_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_s) begin
      s_q <= s_i;
    end
    if (ctrl_i.shift_p) begin
      p_q <= p_i;
    end
  end

  assign s_o  = s_q;
  assign p_o  = p_q;
  assign eq_o = !active_i || (s_q == p_q);
endmodule
`default_nettype wire

FILE: src/mfwf_chain.sv
// Row of compare cells; flags when the last k stream bytes equal the pattern.
`default_nettype none
module mfwf_chain import mfwf_pkg::*; (
  input  wire logic             clk_i,
  input  wire chain_ctrl_t      ctrl_i,
  input  wire logic [WIN_W-1:0] k_i,
  input  wire logic [7:0]       data_i,
  output logic                  match_o
);
  logic [7:0]            s_link [MAX_WINDOW+1];
  logic [7:0]            p_link [MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0] eq;

  assign s_link[0] = data_i;
  assign p_link[0] = data_i;

  for (genvar c = 0; c < MAX_WINDOW; c++) begin : g_cell
    mfwf_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .active_i(k_i > WIN_W'(c)),
      .s_i     (s_link[c]),
      .p_i     (p_link[c]),
      .s_o     (s_link[c+1]),
      .p_o     (p_link[c+1]),
      .eq_o    (eq[c])
    );
  end

  assign match_o = &eq;
endmodule
`default_nettype wire

FILE: src/most_frequent_window_finder.sv
// Top level: text store, window scan sequencer and result emission.
// Load: one byte per cycle while busy_o is low.
// Search: per start i, the pattern row loads the k bytes from i, the text bytes
// 0 to i+k-1 stream past it, the row drains, and the best count updates.
// Emission: min(k,n) results on consecutive cycles; the receiver cannot stall.
// Reset (asynchronous, active low) empties the text; window_length is 1.
`default_nettype none
module most_frequent_window_finder import mfwf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire in_item_t  in_i,
  output logic           result_valid_o,
  output out_item_t      result_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [6:0] cfg_data_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_STREAM, S_WAIT, S_UPDATE, S_EMIT, S_DRAIN
  } state_e;

  state_e            state_q;
  logic [6:0]        wlen_q;
  logic [CNT_W-1:0]  txt_cnt_q, n_q, iss_q, cnt_q, best_cnt_q;
  logic [WIN_W-1:0]  k_q, len_q;
  logic [ADDR_W-1:0] i_q, first_q, best_start_q, rd_a_q, cmp_j_q;
  logic              found_q, rd_v_q, rd_to_p_q, cmp_v_q;
  logic              em_v_q, em_last_q;
  logic [POS_W-1:0]  em_e_q;
  out_item_t         result_q;
  logic              result_valid_q;

  logic              accept, ram_we, match;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        rdata;
  logic [CNT_W-1:0]  n_next, i_plus_k;
  logic [WIN_W-1:0]  k_eff;
  chain_ctrl_t       ctrl;

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign ram_we      = accept && (txt_cnt_q < CNT_W'(MAX_LEN));
  assign n_next      = ram_we ? txt_cnt_q + 1'b1 : txt_cnt_q;
  assign i_plus_k    = {1'b0, i_q} + CNT_W'(k_q);
  assign ctrl.shift_s = rd_v_q && !rd_to_p_q;
  assign ctrl.shift_p = rd_v_q && rd_to_p_q;

  always_comb begin
    if (wlen_q == '0) begin
      k_eff = WIN_W'(1);
    end else if (wlen_q > 7'(MAX_WINDOW)) begin
      k_eff = WIN_W'(MAX_WINDOW);
    end else begin
      k_eff = WIN_W'(wlen_q);
    end
  end

  always_comb begin
    unique case (state_q)
      S_IDLE:   ram_addr = txt_cnt_q[ADDR_W-1:0];
      S_LOAD:   ram_addr = i_q + iss_q[ADDR_W-1:0];
      S_STREAM: ram_addr = iss_q[ADDR_W-1:0];
      S_EMIT:   ram_addr = best_start_q + ADDR_W'(iss_q);
      default:  ram_addr = '0;
    endcase
  end

  mfwf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(in_i.text_byte),
    .rdata_o(rdata)
  );

  mfwf_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .k_i    (k_q),
    .data_i (rdata),
    .match_o(match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      wlen_q         <= 7'd1;
      txt_cnt_q      <= '0;
      n_q            <= '0;
      k_q            <= WIN_W'(1);
      len_q          <= '0;
      iss_q          <= '0;
      i_q            <= '0;
      cnt_q          <= '0;
      found_q        <= 1'b0;
      first_q        <= '0;
      best_cnt_q     <= '0;
      best_start_q   <= '0;
      rd_v_q         <= 1'b0;
      rd_to_p_q      <= 1'b0;
      rd_a_q         <= '0;
      cmp_v_q        <= 1'b0;
      cmp_j_q        <= '0;
      em_v_q         <= 1'b0;
      em_e_q         <= '0;
      em_last_q      <= 1'b0;
      result_valid_q <= 1'b0;
      result_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        wlen_q <= cfg_data_i;
      end

      // read pipeline into the cell row
      rd_v_q    <= (state_q == S_LOAD) || (state_q == S_STREAM);
      rd_to_p_q <= (state_q == S_LOAD);
      rd_a_q    <= ram_addr;
      cmp_v_q   <= ctrl.shift_s && ({1'b0, rd_a_q} >= CNT_W'(k_q) - 1'b1);
      cmp_j_q   <= rd_a_q - (ADDR_W'(k_q) - 1'b1);
      if (cmp_v_q && match) begin
        cnt_q <= cnt_q + 1'b1;
        if (!found_q) begin
          found_q <= 1'b1;
          first_q <= cmp_j_q;
        end
      end

      // emission pipeline
      em_v_q         <= (state_q == S_EMIT);
      em_e_q         <= iss_q[POS_W-1:0];
      em_last_q      <= (iss_q == CNT_W'(len_q) - 1'b1);
      result_valid_q <= em_v_q;
      if (em_v_q) begin
        result_q.out_byte         <= rdata;
        result_q.byte_position    <= em_e_q;
        result_q.window_start     <= best_start_q;
        result_q.occurrence_count <= best_cnt_q;
        result_q.run_end          <= em_last_q;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            txt_cnt_q <= n_next;
            if (in_i.is_last) begin
              txt_cnt_q    <= '0;
              n_q          <= n_next;
              k_q          <= k_eff;
              len_q        <= (CNT_W'(k_eff) <= n_next) ? k_eff : WIN_W'(n_next);
              best_cnt_q   <= '0;
              best_start_q <= '0;
              i_q          <= '0;
              iss_q        <= '0;
              cnt_q        <= '0;
              found_q      <= 1'b0;
              state_q      <= (CNT_W'(k_eff) > n_next) ? S_EMIT : S_LOAD;
            end
          end
        end
        S_LOAD: begin
          if (iss_q == CNT_W'(k_q) - 1'b1) begin
            iss_q   <= '0;
            state_q <= S_STREAM;
          end else begin
            iss_q <= iss_q + 1'b1;
          end
        end
        S_STREAM: begin
          if (iss_q == i_plus_k - 1'b1) begin
            state_q <= S_WAIT;
          end
          iss_q <= iss_q + 1'b1;
        end
        S_WAIT: begin
          if (cmp_v_q && cmp_j_q == i_q) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (first_q == i_q) begin
            if (best_cnt_q <= CNT_W'(1)) begin
              best_start_q <= i_q;
              best_cnt_q   <= CNT_W'(1);
            end
          end else if (cnt_q >= best_cnt_q) begin
            best_start_q <= first_q;
            best_cnt_q   <= cnt_q;
          end
          iss_q   <= '0;
          cnt_q   <= '0;
          found_q <= 1'b0;
          if (i_plus_k < n_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (iss_q == CNT_W'(len_q) - 1'b1) begin
            state_q <= S_DRAIN;
          end
          iss_q <= iss_q + 1'b1;
        end
        S_DRAIN: begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.run_end |=> result_valid_o)
    else $error("result run broken");
  a_pos_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.run_end |=>
      result_o.byte_position == $past(result_o.byte_position) + 1'b1)
    else $error("byte position out of order");
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.is_last |=> busy_o)
    else $error("not busy after last item");
  a_self_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDATE |-> found_q && first_q <= i_q && cnt_q != '0)
    else $error("window failed to match itself");
`endif
endmodule
`default_nettype wire
